// ===== sv/bcz_pkg.sv =====
package bcz_pkg;

  // fixed widths of the payload and the selector word
  localparam int unsigned VALUE_W = 9;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SEL_W   = 32;
  localparam int unsigned COUNT_W = 6;

  // coefficient that stands for a zero byte with its selector bit set
  localparam logic [VALUE_W-1:0] COEF_HIGH = 9'd256;

  // kind codes
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_SEL  = 1'b1;

  // direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               ovf;
  } result_t;

  // selector trailer handed from the state logic to the output stage
  typedef struct packed {
    logic             start;
    logic [SEL_W-1:0] word;
    logic             ovf;
  } tail_t;

endpackage

// ===== sv/byte_codec_with_zero_selector_top.sv =====
// Zero-selector byte codec for coefficients mod 257.
// Input channel: in_valid / in_stall with kind, value, last. Output
// channel: out_valid / out_stall with out_kind, out_value, out_last,
// overflow. Config channel: cfg_valid / cfg_ready / cfg_data sets the
// direction (0 encode, 1 decode); write it only while the block is idle.
// An item passes the input register, then the result register. One item
// is taken per cycle while the output does not stall; in encode mode a
// data item marked last also emits SEL_BYTES selector bytes, one per
// unstalled cycle from the trailer sequencer, while input holds off.
// Selector byte loads in decode mode give no result. Reset (rst,
// synchronous) empties both registers, selects encode and clears the
// zero counter, selector word and overflow flag. When the receiver
// stalls, the result holds; one more item is taken into the input
// register, then in_stall rises until the result drains.
module byte_codec_with_zero_selector_top #(
  parameter int unsigned SEL_BITS  = 32,
  parameter int unsigned SEL_BYTES = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [bcz_pkg::VALUE_W-1:0] value,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_kind,
  output logic [bcz_pkg::VALUE_W-1:0] out_value,
  output logic                        out_last,
  output logic                        overflow,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data
);

  logic             direction;
  logic             a_valid;
  bcz_pkg::item_t   a_item;
  logic             a_move;
  logic             has_result;
  logic             free;
  bcz_pkg::result_t result;
  bcz_pkg::tail_t   tail;

  assign cfg_ready = 1'b1;

  // direction register
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= bcz_pkg::DIR_ENCODE;
    end else if (cfg_valid && cfg_ready) begin
      direction <= cfg_data;
    end
  end

  // input register advances when its result has room, or it has no result
  assign a_move   = a_valid && (!has_result || free);
  assign in_stall = a_valid && !a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      a_valid      <= 1'b1;
      a_item.kind  <= kind;
      a_item.value <= value;
      a_item.last  <= last;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  bcz_state #(
    .SEL_BITS  (SEL_BITS),
    .SEL_BYTES (SEL_BYTES)
  ) u_state (
    .clk        (clk),
    .rst        (rst),
    .direction  (direction),
    .step       (a_move),
    .item       (a_item),
    .has_result (has_result),
    .result     (result),
    .tail       (tail)
  );

  bcz_out #(
    .SEL_BYTES (SEL_BYTES)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (a_move && has_result),
    .res       (result),
    .tail      (tail),
    .out_stall (out_stall),
    .free      (free),
    .out_valid (out_valid),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_last  (out_last),
    .overflow  (overflow)
  );

endmodule

// ===== sv/bcz_state.sv =====
module bcz_state #(
  parameter int unsigned SEL_BITS  = 32,
  parameter int unsigned SEL_BYTES = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             direction,
  input  logic             step,
  input  bcz_pkg::item_t   item,
  output logic             has_result,
  output bcz_pkg::result_t result,
  output bcz_pkg::tail_t   tail
);

  localparam int unsigned TOP_SHIFT = 8 * (SEL_BYTES - 1);

  logic [bcz_pkg::COUNT_W-1:0] zero_count, zero_count_next;
  logic [bcz_pkg::SEL_W-1:0]   selector_word, selector_word_next;
  logic                        overflow_seen, overflow_seen_next;

  logic [bcz_pkg::BYTE_W-1:0]  in_byte;
  logic                        is_zero;
  logic                        in_range;

  assign in_byte  = item.value[bcz_pkg::BYTE_W-1:0];
  assign is_zero  = (in_byte == '0);
  assign in_range = (zero_count < bcz_pkg::COUNT_W'(SEL_BITS));

  // a selector byte never gives a result
  assign has_result = (item.kind == bcz_pkg::KIND_DATA);

  // per-item state update and result
  always_comb begin
    zero_count_next    = zero_count;
    selector_word_next = selector_word;
    overflow_seen_next = overflow_seen;
    result.kind        = bcz_pkg::KIND_DATA;
    result.value       = {1'b0, in_byte};
    result.last        = 1'b0;
    result.ovf         = 1'b0;
    tail.start         = 1'b0;
    tail.word          = selector_word;
    tail.ovf           = overflow_seen;
    if (direction == bcz_pkg::DIR_ENCODE) begin
      if (item.kind == bcz_pkg::KIND_DATA) begin
        if (is_zero) begin
          if (!in_range) begin
            overflow_seen_next = 1'b1;
          end else begin
            if (item.value == bcz_pkg::COEF_HIGH) begin
              selector_word_next[zero_count[4:0]] = 1'b1;
            end
            zero_count_next = zero_count + 1'b1;
          end
        end
        result.ovf = overflow_seen_next;
        tail.word  = selector_word_next;
        tail.ovf   = overflow_seen_next;
        if (item.last) begin
          tail.start         = 1'b1;
          zero_count_next    = '0;
          selector_word_next = '0;
          overflow_seen_next = 1'b0;
        end
      end
    end else begin
      if (item.kind == bcz_pkg::KIND_SEL) begin
        selector_word_next = (selector_word >> bcz_pkg::BYTE_W) |
                             (bcz_pkg::SEL_W'(in_byte) << TOP_SHIFT);
      end else begin
        if (is_zero && in_range) begin
          result.value    = selector_word[zero_count[4:0]] ? bcz_pkg::COEF_HIGH : '0;
          zero_count_next = zero_count + 1'b1;
        end
        result.last = item.last;
        if (item.last) begin
          zero_count_next    = '0;
          selector_word_next = '0;
          overflow_seen_next = 1'b0;
        end
      end
    end
  end

  // codec state
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_count    <= '0;
      selector_word <= '0;
      overflow_seen <= 1'b0;
    end else if (step) begin
      zero_count    <= zero_count_next;
      selector_word <= selector_word_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

// ===== sv/bcz_out.sv =====
module bcz_out #(
  parameter int unsigned SEL_BYTES = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  bcz_pkg::result_t            res,
  input  bcz_pkg::tail_t              tail,
  input  logic                        out_stall,
  output logic                        free,
  output logic                        out_valid,
  output logic                        out_kind,
  output logic [bcz_pkg::VALUE_W-1:0] out_value,
  output logic                        out_last,
  output logic                        overflow
);

  localparam int unsigned CW = $clog2(SEL_BYTES + 1);

  logic [CW-1:0]             trail_cnt;
  logic [bcz_pkg::SEL_W-1:0] trail_word;
  logic                      trail_ovf;

  // a new result may enter when the register empties and no trailer is pending
  assign free = (trail_cnt == '0) && (!out_valid || !out_stall);

  // result register and selector trailer sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      trail_cnt <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      out_kind  <= res.kind;
      out_value <= res.value;
      out_last  <= res.last;
      overflow  <= res.ovf;
      if (tail.start) begin
        trail_cnt  <= CW'(SEL_BYTES);
        trail_word <= tail.word;
        trail_ovf  <= tail.ovf;
      end
    end else if (out_valid && !out_stall) begin
      if (trail_cnt != '0) begin
        out_kind   <= bcz_pkg::KIND_SEL;
        out_value  <= {1'b0, trail_word[bcz_pkg::BYTE_W-1:0]};
        out_last   <= (trail_cnt == CW'(1));
        overflow   <= trail_ovf;
        trail_word <= trail_word >> bcz_pkg::BYTE_W;
        trail_cnt  <= trail_cnt - 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_trail_has_valid: assert property (@(posedge clk) disable iff (rst)
    trail_cnt != '0 |-> out_valid)
    else $error("selector trailer pending with empty result register");

  a_load_when_idle: assert property (@(posedge clk) disable iff (rst)
    load |-> trail_cnt == '0)
    else $error("result loaded over a pending trailer");

  a_trail_start: assert property (@(posedge clk) disable iff (rst)
    load && tail.start |=> trail_cnt == CW'(SEL_BYTES))
    else $error("trailer count not loaded after last coefficient");
`endif

endmodule
